/* rtl/core/address_range_table_macros.svh */
// Assertion macros for the address range table RTL.
`ifndef ADDRESS_RANGE_TABLE_MACROS_SVH
`define ADDRESS_RANGE_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ART_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ART_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/art_pkg.sv */
// Shared types, sizes and codes of the address range table.
package art_pkg;

    localparam int REGION_SLOTS = 16;
    localparam int IDX_W        = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int CNT_W        = $clog2(REGION_SLOTS + 1);
    localparam int ENTRY_W      = 4;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        logic [63:0] base;
        logic [31:0] length;
        logic [31:0] buffer;
    } t_region;

    typedef struct packed {
        logic        hit;
        logic [29:0] word_offset;
        logic [31:0] bytes_left;
    } t_match;

    typedef struct packed {
        t_status              status;
        logic [ENTRY_W-1:0]   entry_index;
        logic [29:0]          word_offset;
        logic [31:0]          bytes_left;
        logic [31:0]          region_buffer;
    } t_result;

    function automatic logic [ENTRY_W-1:0] slot_to_entry(input logic [CNT_W-1:0] slot);
        logic [CNT_W+ENTRY_W-1:0] wide;
        wide = (CNT_W + ENTRY_W)'(slot);
        return wide[ENTRY_W-1:0];
    endfunction

endpackage

/* rtl/core/art_region_ram.sv */
// Region store: one write port and one registered read port.
module art_region_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [art_pkg::IDX_W-1:0]     i_waddr,
    input  art_pkg::t_region              i_wdata,
    input  logic [art_pkg::IDX_W-1:0]     i_raddr,
    output art_pkg::t_region              o_rdata
);

    art_pkg::t_region r_mem [art_pkg::REGION_SLOTS];
    art_pkg::t_region r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/art_match.sv */
// Range test of one stored region against a probe address.
module art_match (
    input  logic [63:0]          i_addr,
    input  art_pkg::t_region     i_region,
    output art_pkg::t_match      o_match
);

    logic [64:0] w_diff_ext;
    logic [63:0] w_diff;
    logic        w_ge;

    assign w_diff_ext = {1'b0, i_addr} - {1'b0, i_region.base};
    assign w_ge       = ~w_diff_ext[64];
    assign w_diff     = w_diff_ext[63:0];

    always_comb begin
        o_match.hit         = w_ge && ((w_diff == 64'd0) || (w_diff < {32'd0, i_region.length}));
        o_match.word_offset = w_diff[31:2];
        o_match.bytes_left  = i_region.length - w_diff[31:0];
    end

endmodule

/* rtl/core/address_range_table.sv */
// Top level of the address range table.
// An append word stores base, length and buffer reference in the next free slot
// and answers with the slot it used, or reports the table full. A lookup word reads the
// region memory one slot per cycle in append order and stops at the first
// region whose base equals the address or strictly contains it. One word is
// worked on at a time; the next is taken while the previous result still waits
// at the output. Reset empties the table at once.
`include "address_range_table_macros.svh"

module address_range_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [63:0] i_address,
    input  logic [31:0] i_length,
    input  logic [31:0] i_buffer_ref,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [3:0]  o_entry_index,
    output logic [29:0] o_word_offset,
    output logic [31:0] o_bytes_left,
    output logic [31:0] o_region_buffer
);

    localparam int CNT_W = art_pkg::CNT_W;
    localparam int IDX_W = art_pkg::IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_rd_idx;
    logic [CNT_W-1:0]   r_cmp_idx;
    logic               r_cmp_vld;
    logic [63:0]        r_addr;
    art_pkg::t_result   r_res;
    art_pkg::t_result   r_o_res;
    logic               r_o_valid;

    logic               w_accept;
    logic               w_out_free;
    logic               w_load;
    logic               w_full;
    logic               w_we;
    art_pkg::t_region   w_wdata;
    art_pkg::t_region   w_rd_data;
    art_pkg::t_match    w_match;
    art_pkg::t_result   w_none;
    art_pkg::t_result   w_app_res;

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_o_valid || i_ready;
    assign w_load     = (r_state == S_RESP) && w_out_free;
    assign w_full     = (r_count == CNT_W'(art_pkg::REGION_SLOTS));
    assign w_we       = w_accept && !i_mode && !w_full;

    always_comb begin
        w_wdata.base   = i_address;
        w_wdata.length = i_length;
        w_wdata.buffer = i_buffer_ref;
        w_none.status        = art_pkg::ST_NOT_FOUND;
        w_none.entry_index   = '0;
        w_none.word_offset   = '0;
        w_none.bytes_left    = '0;
        w_none.region_buffer = '0;
        w_app_res = w_none;
        if (w_full) begin
            w_app_res.status = art_pkg::ST_FULL;
        end else begin
            w_app_res.status      = art_pkg::ST_OK;
            w_app_res.entry_index = art_pkg::slot_to_entry(r_count);
        end
    end

    art_region_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (w_rd_data)
    );

    art_match u_match (
        .i_addr   (r_addr),
        .i_region (w_rd_data),
        .o_match  (w_match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_addr    <= i_address;
                        r_rd_idx  <= '0;
                        r_cmp_vld <= 1'b0;
                        if (!i_mode) begin
                            r_state <= S_RESP;
                            r_res   <= w_app_res;
                            if (!w_full) begin
                                r_count <= r_count + CNT_W'(1);
                            end
                        end else if (r_count == '0) begin
                            r_res   <= w_none;
                            r_state <= S_RESP;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_rd_idx  <= r_rd_idx + CNT_W'(1);
                    r_cmp_idx <= r_rd_idx;
                    if (r_cmp_vld && w_match.hit) begin
                        r_res.status        <= art_pkg::ST_OK;
                        r_res.entry_index   <= art_pkg::slot_to_entry(r_cmp_idx);
                        r_res.word_offset   <= w_match.word_offset;
                        r_res.bytes_left    <= w_match.bytes_left;
                        r_res.region_buffer <= w_rd_data.buffer;
                        r_cmp_vld           <= 1'b0;
                        r_state             <= S_RESP;
                    end else if (r_cmp_vld && ((r_cmp_idx + CNT_W'(1)) == r_count)) begin
                        r_res     <= w_none;
                        r_cmp_vld <= 1'b0;
                        r_state   <= S_RESP;
                    end else begin
                        r_cmp_vld <= 1'b1;
                    end
                end
                S_RESP: begin
                    if (w_out_free) begin
                        r_o_res <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_o_valid;
    assign o_status        = r_o_res.status;
    assign o_entry_index   = r_o_res.entry_index;
    assign o_word_offset   = r_o_res.word_offset;
    assign o_bytes_left    = r_o_res.bytes_left;
    assign o_region_buffer = r_o_res.region_buffer;

    `ART_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(art_pkg::REGION_SLOTS), "Region count exceeds the table size.")
    `ART_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept,
        r_state != S_IDLE, "Block stayed idle after taking a word.")
    `ART_ASSERT_NEXT(a_append_count, i_clk, i_rst_n, w_we,
        r_count == $past(r_count) + CNT_W'(1), "Append did not advance the region count.")
    `ART_ASSERT_SAME(a_scan_range, i_clk, i_rst_n, (r_state == S_SCAN) && r_cmp_vld,
        r_cmp_idx < r_count, "Lookup compared a slot beyond the region count.")
    `ART_ASSERT_NEXT(a_resp_out, i_clk, i_rst_n, (r_state == S_RESP) && w_out_free,
        o_valid && (r_state == S_IDLE), "Finished result did not reach the output.")

endmodule

/* sim/address_range_table_tb.sv */
// Self-checking testbench for the address range table: appends, lookups and a full table.
`timescale 1ns / 100ps

module address_range_table_tb;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_mode = MODE_APPEND;
    logic [63:0] i_address = '0;
    logic [31:0] i_length = '0;
    logic [31:0] i_buffer_ref = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [3:0]  o_entry_index;
    logic [29:0] o_word_offset;
    logic [31:0] o_bytes_left;
    logic [31:0] o_region_buffer;

    logic [63:0] known_base [art_pkg::REGION_SLOTS];
    logic [31:0] known_len [art_pkg::REGION_SLOTS];
    logic [31:0] known_buf [art_pkg::REGION_SLOTS];
    int          known_count = 0;

    art_pkg::t_result expected_results [$];
    int          error_count = 0;
    int          burst_left = 4;
    int          ready_style = 0;
    int          ready_span = 0;
    int          ready_tick = 0;

    address_range_table uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_mode(i_mode),
        .i_address(i_address),
        .i_length(i_length),
        .i_buffer_ref(i_buffer_ref),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_status(o_status),
        .o_entry_index(o_entry_index),
        .o_word_offset(o_word_offset),
        .o_bytes_left(o_bytes_left),
        .o_region_buffer(o_region_buffer)
    );

    always #5 i_clk = ~i_clk;

    function automatic art_pkg::t_result resolve_word(input logic mode, input logic [63:0] addr,
                                             input logic [31:0] len, input logic [31:0] bref);
        art_pkg::t_result r;
        logic [63:0] diff;
        r = '0;
        if (mode == MODE_APPEND) begin
            if (known_count >= art_pkg::REGION_SLOTS) begin
                r.status = art_pkg::ST_FULL;
            end else begin
                known_base[known_count] = addr;
                known_len[known_count] = len;
                known_buf[known_count] = bref;
                r.status = art_pkg::ST_OK;
                r.entry_index = 4'(known_count);
                known_count++;
            end
            return r;
        end
        for (int s = 0; s < known_count; s++) begin
            if (addr >= known_base[s]) begin
                diff = addr - known_base[s];
                if (diff == 64'd0 || diff < {32'h0, known_len[s]}) begin
                    r.status = art_pkg::ST_OK;
                    r.entry_index = 4'(s);
                    r.word_offset = diff[31:2];
                    r.bytes_left = known_len[s] - diff[31:0];
                    r.region_buffer = known_buf[s];
                    return r;
                end
            end
        end
        r.status = art_pkg::ST_NOT_FOUND;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t MISMATCH %s: got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_word(input logic mode, input logic [63:0] addr,
                             input logic [31:0] len, input logic [31:0] bref);
        i_valid <= 1'b1;
        i_mode <= mode;
        i_address <= addr;
        i_length <= len;
        i_buffer_ref <= bref;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_results.push_back(resolve_word(mode, addr, len, bref));
        burst_left--;
        if (burst_left <= 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 20 : 3)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic append_random_region();
        logic [63:0] base;
        logic [31:0] len;
        case ($urandom_range(0, 7))
            0, 1: base = {32'h0, $urandom};
            2: base = {32'hFFFF_FFFF, $urandom};
            default: base = {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 7))
            0: len = 32'h0;
            1: len = 32'hFFFF_FFFF;
            2, 3: len = $urandom_range(1, 64);
            4, 5: len = $urandom_range(1, 65536);
            default: len = $urandom;
        endcase
        send_word(MODE_APPEND, base, len, $urandom);
    endtask

    task automatic test_empty_lookup();
        send_word(MODE_LOOKUP, 64'h0, 32'h0, 32'h0);
        send_word(MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_region_edges();
        send_word(MODE_APPEND, 64'h1000, 32'h100, 32'hA5A5_0000);
        send_word(MODE_APPEND, 64'h1080, 32'h100, 32'h5A5A_0001);
        send_word(MODE_APPEND, 64'h5000, 32'h0, 32'h0000_0002);
        send_word(MODE_APPEND, 64'hFFFF_FFFF_FFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(MODE_APPEND, 64'h2_0000_0000, 32'hFFFF_FFFF, 32'h1234_5678);
        send_word(MODE_LOOKUP, 64'h1000, $urandom, $urandom);
        send_word(MODE_LOOKUP, 64'h10FF, $urandom, $urandom);
        send_word(MODE_LOOKUP, 64'h1100, $urandom, $urandom);
        send_word(MODE_LOOKUP, 64'h1180, $urandom, $urandom);
        send_word(MODE_LOOKUP, 64'h0FFF, $urandom, $urandom);
        send_word(MODE_LOOKUP, 64'h5000, $urandom, $urandom);
        send_word(MODE_LOOKUP, 64'h5001, $urandom, $urandom);
        send_word(MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, $urandom, $urandom);
        send_word(MODE_LOOKUP, 64'h2_FFFF_FFFE, $urandom, $urandom);
        send_word(MODE_LOOKUP, 64'h2_FFFF_FFFF, $urandom, $urandom);
    endtask

    task automatic test_random_traffic(input int n_words);
        int          slot;
        logic [63:0] addr;
        logic [63:0] span64;
        for (int k = 0; k < n_words; k++) begin
            if ($urandom_range(0, 24) == 0) begin
                append_random_region();
            end else if (known_count > 0 && $urandom_range(0, 9) < 7) begin
                slot = $urandom_range(0, known_count - 1);
                span64 = {32'h0, known_len[slot]};
                case ($urandom_range(0, 6))
                    0: addr = known_base[slot];
                    1: addr = known_base[slot] + span64 - 64'd1;
                    2: addr = known_base[slot] + span64;
                    3: addr = known_base[slot] - 64'd1;
                    4: addr = known_base[slot] + span64 + 64'd1;
                    default: addr = known_base[slot] + ({32'h0, $urandom} % (span64 + 64'd1));
                endcase
                send_word(MODE_LOOKUP, addr, $urandom, $urandom);
            end else begin
                addr = {$urandom, $urandom};
                if ($urandom_range(0, 2) == 0) addr[63:32] = 32'h0;
                send_word(MODE_LOOKUP, addr, $urandom, $urandom);
            end
        end
    endtask

    task automatic test_table_full();
        while (known_count < art_pkg::REGION_SLOTS) append_random_region();
        send_word(MODE_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(MODE_APPEND, 64'h0, 32'h0, 32'h0);
        send_word(MODE_LOOKUP, known_base[art_pkg::REGION_SLOTS-1], $urandom, $urandom);
    endtask

    always @(posedge i_clk) begin
        if (ready_span == 0) begin
            ready_style = $urandom_range(0, 3);
            ready_span = $urandom_range(50, 300);
        end
        ready_span--;
        ready_tick++;
        case (ready_style)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(0, 1));
            2: i_ready <= (ready_tick % 5) != 0;
            default: i_ready <= (ready_tick % 24) == 0;
        endcase
    end

    always @(posedge i_clk) begin
        art_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected word", {62'h0, o_status}, 64'h0);
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 64'(o_status), 64'(want.status));
                if (o_entry_index !== want.entry_index)
                    report_mismatch("entry_index", 64'(o_entry_index), 64'(want.entry_index));
                if (o_word_offset !== want.word_offset)
                    report_mismatch("word_offset", 64'(o_word_offset), 64'(want.word_offset));
                if (o_bytes_left !== want.bytes_left)
                    report_mismatch("bytes_left", 64'(o_bytes_left), 64'(want.bytes_left));
                if (o_region_buffer !== want.region_buffer)
                    report_mismatch("region_buffer", 64'(o_region_buffer),
                                    64'(want.region_buffer));
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_lookup();
        test_region_edges();
        test_random_traffic(850);
        test_table_full();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/art_pkg.sv
rtl/core/art_region_ram.sv
rtl/core/art_match.sv
rtl/core/address_range_table.sv
sim/address_range_table_tb.sv
